FILE: src/pfc_pkg.sv
`default_nettype none

package pfc_pkg;

	// Packed pixel formats, as coded in the format registers.
	typedef enum logic [1:0] {
		FMT_5650 = 2'd0,
		FMT_5551 = 2'd1,
		FMT_4444 = 2'd2,
		FMT_8888 = 2'd3
	} fmt_t;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_FORMAT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_FORMAT = 2'd1;

	localparam int unsigned PIX_W = 32;

	// One pixel with every channel widened to eight bits.
	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} chan8_t;

endpackage : pfc_pkg

`default_nettype wire

FILE: src/pfc_unpack.sv
`default_nettype none

module pfc_unpack (
	input  wire logic [31:0]  pixel,
	input  wire pfc_pkg::fmt_t     fmt,
	output pfc_pkg::chan8_t   chan
);
	import pfc_pkg::*;

	// Each channel is widened by repeating its bit pattern from the top.
	always_comb begin
		case (fmt)
			FMT_5650: begin
				chan.red   = {pixel[4:0],   pixel[4:2]};
				chan.green = {pixel[10:5],  pixel[10:9]};
				chan.blue  = {pixel[15:11], pixel[15:13]};
				chan.alpha = 8'hff;
			end
			FMT_5551: begin
				chan.red   = {pixel[4:0],   pixel[4:2]};
				chan.green = {pixel[9:5],   pixel[9:7]};
				chan.blue  = {pixel[14:10], pixel[14:12]};
				chan.alpha = {8{pixel[15]}};
			end
			FMT_4444: begin
				chan.red   = {pixel[3:0],   pixel[3:0]};
				chan.green = {pixel[7:4],   pixel[7:4]};
				chan.blue  = {pixel[11:8],  pixel[11:8]};
				chan.alpha = {pixel[15:12], pixel[15:12]};
			end
			default: begin
				chan.red   = pixel[7:0];
				chan.green = pixel[15:8];
				chan.blue  = pixel[23:16];
				chan.alpha = pixel[31:24];
			end
		endcase
	end

endmodule : pfc_unpack

`default_nettype wire

FILE: src/pfc_pack.sv
`default_nettype none

module pfc_pack (
	input  wire pfc_pkg::chan8_t   chan,
	input  wire pfc_pkg::fmt_t     fmt,
	output logic [31:0]       pixel
);
	import pfc_pkg::*;

	// Each channel keeps its top bits; 16-bit formats leave the upper half zero.
	always_comb begin
		case (fmt)
			FMT_5650: pixel = {16'h0000, chan.blue[7:3], chan.green[7:2], chan.red[7:3]};
			FMT_5551: pixel = {16'h0000, chan.alpha[7], chan.blue[7:3], chan.green[7:3],
				chan.red[7:3]};
			FMT_4444: pixel = {16'h0000, chan.alpha[7:4], chan.blue[7:4], chan.green[7:4],
				chan.red[7:4]};
			default:  pixel = {chan.alpha, chan.blue, chan.green, chan.red};
		endcase
	end

endmodule : pfc_pack

`default_nettype wire

FILE: src/pixel_format_converter.sv
// Pixel format converter: turns one packed pixel per word from the source format
// into the target format (5650, 5551, 4444 or 8888, red lowest, alpha highest).
// Input channel: in_valid / in_ready with pixel_in; 16-bit formats use its low half.
// Output channel: out_valid / out_ready with pixel_out; 16-bit targets give a zero
// upper half. Configuration channel: cfg_valid / cfg_ready with cfg_index and
// cfg_data; index 0 is the source format, index 1 the target format, any other
// index is ignored. cfg_ready is always high, and the formats are to be changed
// only while no word is in flight.
// A word accepted by the input channel is held in the input register, converted by
// a short decode and repack, and captured in the output register that drives
// pixel_out. The two registers form a pipeline that takes one word every cycle
// as long as the receiver keeps out_ready high.
// When the receiver stalls, the result stays in the output register and one
// further word waits in the input register; in_ready then falls until the
// output register is drained.
// Reset clears both valid flags and sets both formats to 8888.
`default_nettype none

module pixel_format_converter (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [pfc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [pfc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [pfc_pkg::PIX_W-1:0]       pixel_in,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [pfc_pkg::PIX_W-1:0]            pixel_out
);
	import pfc_pkg::*;

	fmt_t               source_fmt_q;
	fmt_t               target_fmt_q;
	logic               valid_s1;
	logic [PIX_W-1:0]   pixel_s1;
	logic               valid_s2;
	logic [PIX_W-1:0]   pixel_s2;
	logic               advance;
	chan8_t             chan;
	logic [PIX_W-1:0]   converted;

	// Register writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_fmt_q <= FMT_8888;
			target_fmt_q <= FMT_8888;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SOURCE_FORMAT: source_fmt_q <= fmt_t'(cfg_data);
				CFG_TARGET_FORMAT: target_fmt_q <= fmt_t'(cfg_data);
				default: ;
			endcase
		end
	end

	// The first stage moves on whenever the output register is empty or being read.
	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			pixel_s1 <= pixel_in;
		end
		if (advance && valid_s1) begin
			pixel_s2 <= converted;
		end
	end

	// Widen every channel to eight bits, then cut to the target widths. When both
	// formats match, this round trip gives back the pixel, with a zero upper half in 16-bit formats.
	pfc_unpack u_unpack (
		.pixel (pixel_s1),
		.fmt   (source_fmt_q),
		.chan  (chan)
	);

	pfc_pack u_pack (
		.chan  (chan),
		.fmt   (target_fmt_q),
		.pixel (converted)
	);

	assign out_valid = valid_s2;
	assign pixel_out = pixel_s2;

`ifndef SYNTHESIS
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1 && (pixel_s1 == $past(pixel_in)))
		else $error("accepted word did not reach the input register");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(pixel_s1))
		else $error("input register changed while the output was stalled");

	a_narrow_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance && target_fmt_q != FMT_8888 |=> pixel_out[31:16] == 16'h0000)
		else $error("16-bit result has a non-zero upper half");

	a_cfg_source: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && cfg_index == CFG_SOURCE_FORMAT
		|=> source_fmt_q == fmt_t'($past(cfg_data)))
		else $error("source format write was lost");
`endif

endmodule : pixel_format_converter

`default_nettype wire
